[rtl/moving_window_rms_of_difference_unit_macros.svh]
// assertion macros shared by the moving window rms unit
`ifndef MOVING_WINDOW_RMS_OF_DIFFERENCE_UNIT_MACROS_SVH
`define MOVING_WINDOW_RMS_OF_DIFFERENCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MWR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define MWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next cycle check failed");
`else
`define MWR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MWR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mwr_pkg.sv]
// shared constants and types of the moving window rms unit
`timescale 1ns / 1ps
package mwr_pkg;
	localparam int WINDOW      = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W       = SQ_W + $clog2(WINDOW);
	localparam int CNT_W       = $clog2(WINDOW + 1);
	localparam int SLOT_W      = $clog2(WINDOW);
	localparam int ROOT_W      = SAMPLE_BITS;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int SREM_W      = ROOT_W + 2;
	localparam int ITER_W      = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             full;
	} win_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_EVICT,
		FR_COMMIT
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_DONE
	} back_state_t;
endpackage

[rtl/mwr_front.sv]
// front part: squares each sample, keeps the ring of squares and the running sum
`timescale 1ns / 1ps
`include "moving_window_rms_of_difference_unit_macros.svh"
module mwr_front
	import mwr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] diff_sample,
	input  queue_stat_t            qstat,
	output logic                   push,
	output win_t                   push_data
);
	front_state_t        state_q, state_nxt;
	logic [SQ_W-1:0]     ring_q [WINDOW];
	logic [SQ_W-1:0]     sq_q;
	logic [SQ_W-1:0]     old_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] prod;
	logic                accept;
	logic                win_full;
	logic [SUM_W-1:0]    sum_nxt;
	logic [CNT_W-1:0]    count_nxt;

	// most negative sample maps to 2^(SAMPLE_BITS-1), which still fits unsigned
	assign mag      = diff_sample[SAMPLE_BITS-1] ? (~diff_sample + 1'b1) : diff_sample;
	assign prod     = mag * mag;
	assign win_full = (count_q == CNT_W'(WINDOW));
	assign sum_nxt  = sum_q + SUM_W'(sq_q);
	assign count_nxt = win_full ? count_q : count_q + 1'b1;

	always_comb begin
		state_nxt    = state_q;
		sample_stall = 1'b1;
		push         = 1'b0;
		case (state_q)
			FR_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					state_nxt = FR_EVICT;
				end
			end
			FR_EVICT: begin
				state_nxt = FR_COMMIT;
			end
			FR_COMMIT: begin
				if (!qstat.full) begin
					push      = 1'b1;
					state_nxt = FR_IDLE;
				end
			end
			default: begin
				state_nxt = FR_IDLE;
			end
		endcase
	end

	assign accept = sample_valid && !sample_stall;

	assign push_data.sum   = sum_nxt;
	assign push_data.count = count_nxt;
	assign push_data.full  = (count_nxt == CNT_W'(WINDOW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ring store: oldest entry is fetched at accept, replaced at commit
	always_ff @(posedge clk) begin
		if (push) begin
			ring_q[slot_q] <= sq_q;
		end
		if (accept) begin
			old_q <= ring_q[slot_q];
			sq_q  <= prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			slot_q  <= '0;
		end else begin
			if (state_q == FR_EVICT && win_full) begin
				sum_q <= sum_q - SUM_W'(old_q);
			end
			if (push) begin
				sum_q   <= sum_nxt;
				count_q <= count_nxt;
				slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	`MWR_ASSERT_IMPLY(a_count_in_range, clk, arst_n, 1'b1, count_q <= CNT_W'(WINDOW))
	`MWR_ASSERT_NEXT(a_accept_evicts, clk, arst_n, accept, state_q == FR_EVICT)
endmodule

[rtl/mwr_queue.sv]
// two-entry queue of window totals between front and back
`timescale 1ns / 1ps
`include "moving_window_rms_of_difference_unit_macros.svh"
module mwr_queue
	import mwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  win_t        push_data,
	input  logic        pop,
	output win_t        pop_data,
	output queue_stat_t qstat
);
	win_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`MWR_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !qstat.full || pop)
endmodule

[rtl/mwr_back.sv]
// back part: serial divide by the count, serial square root, result register
`timescale 1ns / 1ps
`include "moving_window_rms_of_difference_unit_macros.svh"
module mwr_back
	import mwr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  queue_stat_t       qstat,
	input  win_t              pop_data,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [ROOT_W-1:0] rms_value,
	output logic [CNT_W-1:0]  samples_held,
	output logic              window_full
);
	back_state_t         state_q, state_nxt;
	logic [ITER_W-1:0]   iter_q;
	logic [SUM_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    dvs_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_hold_q;
	logic                full_hold_q;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SREM_W-1:0]   srem_q;
	logic                out_valid_q;
	logic                load;
	logic                div_last;
	logic                sqrt_last;
	logic [CNT_W:0]      rem_sh;
	logic                div_ge;
	logic [SUM_W-1:0]    dvd_nxt;
	logic [SREM_W+1:0]   srem_t;
	logic [SREM_W+1:0]   trial;
	logic                sqrt_ge;

	// restoring divide step, quotient bits shift in behind the dividend
	assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
	assign div_ge  = (rem_sh >= {1'b0, dvs_q});
	assign dvd_nxt = {dvd_q[SUM_W-2:0], div_ge};

	// digit by digit root, two radicand bits per step
	assign srem_t  = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign sqrt_ge = (srem_t >= trial);

	assign div_last  = (state_q == BK_DIV) && (iter_q == ITER_W'(SUM_W - 1));
	assign sqrt_last = (state_q == BK_SQRT) && (iter_q == ITER_W'(ROOT_W - 1));

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop       = 1'b1;
					state_nxt = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_nxt = BK_SQRT;
				end
			end
			BK_SQRT: begin
				if (sqrt_last) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || !result_stall) begin
					load      = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == BK_IDLE || div_last || sqrt_last) begin
				iter_q <= '0;
			end else begin
				iter_q <= iter_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				dvd_q       <= pop_data.sum;
				dvs_q       <= pop_data.count;
				cnt_hold_q  <= pop_data.count;
				full_hold_q <= pop_data.full;
				rem_q       <= '0;
			end
			BK_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= div_ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
				if (div_last) begin
					// the mean never exceeds the largest square, so it fits the radicand
					rad_q  <= dvd_nxt[RAD_W-1:0];
					root_q <= '0;
					srem_q <= '0;
				end
			end
			BK_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], sqrt_ge};
				srem_q <= sqrt_ge ? SREM_W'(srem_t - trial) : srem_t[SREM_W-1:0];
			end
			default: begin
			end
		endcase
		if (load) begin
			rms_value    <= root_q;
			samples_held <= cnt_hold_q;
			window_full  <= full_hold_q;
		end
	end

	assign result_valid = out_valid_q;

	`MWR_ASSERT_NEXT(a_div_then_root, clk, arst_n, state_q == BK_DIV && div_last, state_q == BK_SQRT)
endmodule

[rtl/moving_window_rms_of_difference_unit.sv]
// top level of the moving window rms unit
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  sample   | sample_valid / sample_stall  | diff_sample[15:0] signed
//  result   | result_valid / result_stall  | rms_value[15:0], samples_held[6:0], window_full
//
// the front takes a new request only in its idle state, after the last one is pushed, and
// waits in its commit state while the queue is full; a result passes the front's evict and
// commit states, the queue, a pop, 37 divide steps, 16 root steps and a load into the
// result register; the back pops a new total only after the last result is loaded; reset
// clears sum, count and slot at once; the ring store needs no clearing pass
// a two-entry queue and the result register let either side stall independently
`timescale 1ns / 1ps
module moving_window_rms_of_difference_unit
	import mwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] diff_sample,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] rms_value,
	output logic [6:0]  samples_held,
	output logic        window_full
);
	queue_stat_t qstat;
	logic        push;
	logic        pop;
	win_t        push_data;
	win_t        pop_data;

	mwr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.diff_sample  (diff_sample[SAMPLE_BITS-1:0]),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	mwr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	mwr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.rms_value    (rms_value),
		.samples_held (samples_held),
		.window_full  (window_full)
	);
endmodule
